// ===== rtl/suaihp_pkg.sv =====
// Package for the SUA indication header parser.
// Holds the parse phase type and the configuration register indexes.
// It has no dependencies.
`default_nettype none

package suaihp_pkg;

    // Parse phases, in the order in which the message layout is walked.
    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_MASK   = 4'd1,
        PH_SEQ    = 4'd2,
        PH_CDLEN  = 4'd3,
        PH_CDADDR = 4'd4,
        PH_CGLEN  = 4'd5,
        PH_CGADDR = 4'd6,
        PH_RR     = 4'd7,
        PH_DLEN0  = 4'd8,
        PH_DLEN1  = 4'd9,
        PH_DATA   = 4'd10,
        PH_POST   = 4'd11,
        PH_TAIL   = 4'd12
    } phase_t;

    // Configuration register indexes (word address).
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_FORMAT_MODE = 2'd0;
    localparam reg_idx_t REG_SEQ_MASK    = 2'd1;
    localparam reg_idx_t REG_IMP_MASK    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic       FORMAT_MODE_RESET = 1'b0;
    localparam logic [7:0] SEQ_MASK_RESET    = 8'h01;
    localparam logic [7:0] IMP_MASK_RESET    = 8'h01;

    // Header bytes skipped before the mask byte, less one.
    localparam logic [15:0] HDR_LAST_POS = 16'd7;

    // Shortest accepted message, as the position of its last byte.
    localparam logic [15:0] MIN_LAST_POS_UNITDATA = 16'd13;
    localparam logic [15:0] MIN_LAST_POS_NOTICE   = 16'd14;

endpackage

`default_nettype wire

// ===== rtl/sua_indication_header_parser.sv =====
// Top level of the SUA indication header parser.
// Walks a message one byte a transfer and reports field values and locations.
// Depends on suaihp_pkg.
//
//  Channel   Signals                               Direction  Meaning
//  ------    ------------------------------------  ---------  -------------------------------
//  in        in_valid/in_ready, data_byte, last_byte   sink    one message byte per transfer
//  out       out_valid/out_ready, parse_ok .. importance  source one result per message
//  apb       psel/penable/pwrite/paddr/pwdata/prdata    slave  format and mask registers
//
// A new byte can be accepted every cycle while the input is not stalled. The
// parse state is updated at the edge that accepts a byte, and the last byte
// of a message loads the result register, so a result appears in the cycle
// after its last byte. The single result register lets the input run while
// a result waits; input stalls only when that register is full and out_ready
// is low. Reset clears the parse state and loads the register defaults.
`default_nettype none

module sua_indication_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Byte input.
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    // Result output.
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             parse_ok,
    output logic [7:0]       fields_mask,
    output logic [31:0]      sequence_control,
    output logic [15:0]      called_offset,
    output logic [7:0]       called_length,
    output logic [15:0]      calling_offset,
    output logic [7:0]       calling_length,
    output logic [7:0]       return_reason,
    output logic [15:0]      payload_offset,
    output logic [15:0]      payload_length,
    output logic [7:0]       importance,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers.
    logic       mode_reg;
    logic [7:0] seq_mask_reg;
    logic [7:0] imp_mask_reg;

    // Parse state.
    suaihp_pkg::phase_t phase_reg, phase_next;
    logic [15:0] pos_reg;
    logic [15:0] count_reg, count_next;
    logic [31:0] shift_reg, shift_next;
    logic        err_reg;

    // Captured fields.
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  rr_reg, rr_next;
    logic [7:0]  imp_reg, imp_next;
    logic [7:0]  cdlen_reg, cdlen_next;
    logic [7:0]  cglen_reg, cglen_next;
    logic [31:0] seq_reg, seq_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] cdoff_reg, cdoff_next;
    logic [15:0] cgoff_reg, cgoff_next;
    logic [15:0] poff_reg, poff_next;

    // Result register.
    logic        out_valid_reg;
    logic        ok_next;
    logic        in_xfer;
    logic [15:0] pos_inc;
    logic [15:0] len_field;
    logic        last_of_field;

    assign pready    = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign pos_inc   = pos_reg + 16'd1;
    assign len_field = {data_byte, shift_reg[7:0]};
    assign last_of_field = (count_reg <= 16'd1);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= suaihp_pkg::FORMAT_MODE_RESET;
            seq_mask_reg <= suaihp_pkg::SEQ_MASK_RESET;
            imp_mask_reg <= suaihp_pkg::IMP_MASK_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                suaihp_pkg::REG_FORMAT_MODE: mode_reg     <= pwdata[0];
                suaihp_pkg::REG_SEQ_MASK:    seq_mask_reg <= pwdata[7:0];
                suaihp_pkg::REG_IMP_MASK:    imp_mask_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            suaihp_pkg::REG_FORMAT_MODE: prdata = {31'd0, mode_reg};
            suaihp_pkg::REG_SEQ_MASK:    prdata = {24'd0, seq_mask_reg};
            suaihp_pkg::REG_IMP_MASK:    prdata = {24'd0, imp_mask_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Effect of one byte on the parse state.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        mask_next  = mask_reg;
        rr_next    = rr_reg;
        imp_next   = imp_reg;
        cdlen_next = cdlen_reg;
        cglen_next = cglen_reg;
        seq_next   = seq_reg;
        plen_next  = plen_reg;
        cdoff_next = cdoff_reg;
        cgoff_next = cgoff_reg;
        poff_next  = poff_reg;
        unique case (phase_reg)
            suaihp_pkg::PH_HDR:
            begin
                if (pos_reg >= suaihp_pkg::HDR_LAST_POS)
                    phase_next = suaihp_pkg::PH_MASK;
            end
            suaihp_pkg::PH_MASK:
            begin
                mask_next = data_byte;
                if (!mode_reg && ((data_byte & seq_mask_reg) != 8'd0))
                begin
                    count_next = 16'd4;
                    shift_next = 32'd0;
                    phase_next = suaihp_pkg::PH_SEQ;
                end
                else
                    phase_next = suaihp_pkg::PH_CDLEN;
            end
            suaihp_pkg::PH_SEQ:
            begin
                shift_next = {data_byte, shift_reg[31:8]};
                if (last_of_field)
                begin
                    seq_next   = {data_byte, shift_reg[31:8]};
                    count_next = 16'd0;
                    phase_next = suaihp_pkg::PH_CDLEN;
                end
                else
                    count_next = count_reg - 16'd1;
            end
            suaihp_pkg::PH_CDLEN:
            begin
                cdlen_next = data_byte;
                cdoff_next = pos_inc;
                count_next = {8'd0, data_byte};
                phase_next = (data_byte == 8'd0) ? suaihp_pkg::PH_CGLEN
                                                 : suaihp_pkg::PH_CDADDR;
            end
            suaihp_pkg::PH_CDADDR:
            begin
                if (last_of_field)
                begin
                    count_next = 16'd0;
                    phase_next = suaihp_pkg::PH_CGLEN;
                end
                else
                    count_next = count_reg - 16'd1;
            end
            suaihp_pkg::PH_CGLEN:
            begin
                cglen_next = data_byte;
                cgoff_next = pos_inc;
                count_next = {8'd0, data_byte};
                if (data_byte != 8'd0)
                    phase_next = suaihp_pkg::PH_CGADDR;
                else
                    phase_next = mode_reg ? suaihp_pkg::PH_RR : suaihp_pkg::PH_DLEN0;
            end
            suaihp_pkg::PH_CGADDR:
            begin
                if (last_of_field)
                begin
                    count_next = 16'd0;
                    phase_next = mode_reg ? suaihp_pkg::PH_RR : suaihp_pkg::PH_DLEN0;
                end
                else
                    count_next = count_reg - 16'd1;
            end
            suaihp_pkg::PH_RR:
            begin
                rr_next    = data_byte;
                phase_next = suaihp_pkg::PH_DLEN0;
            end
            suaihp_pkg::PH_DLEN0:
            begin
                shift_next = {24'd0, data_byte};
                phase_next = suaihp_pkg::PH_DLEN1;
            end
            suaihp_pkg::PH_DLEN1:
            begin
                plen_next  = len_field;
                poff_next  = pos_inc;
                count_next = len_field;
                phase_next = (len_field == 16'd0) ? suaihp_pkg::PH_POST
                                                  : suaihp_pkg::PH_DATA;
            end
            suaihp_pkg::PH_DATA:
            begin
                if (last_of_field)
                begin
                    count_next = 16'd0;
                    phase_next = suaihp_pkg::PH_POST;
                end
                else
                    count_next = count_reg - 16'd1;
            end
            suaihp_pkg::PH_POST:
            begin
                if (mode_reg && ((mask_reg & imp_mask_reg) != 8'd0))
                    imp_next = data_byte;
                phase_next = suaihp_pkg::PH_TAIL;
            end
            default:
                phase_next = suaihp_pkg::PH_TAIL;
        endcase
    end

    // The message passes if it is long enough, not overlong, and the data fit.
    always_comb
    begin
        ok_next = !err_reg && (phase_next >= suaihp_pkg::PH_POST)
                  && (pos_reg >= (mode_reg ? suaihp_pkg::MIN_LAST_POS_NOTICE
                                           : suaihp_pkg::MIN_LAST_POS_UNITDATA));
    end

    // Parse state update; the last byte rearms for the next message.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= suaihp_pkg::PH_HDR;
            pos_reg   <= 16'd0;
            count_reg <= 16'd0;
            shift_reg <= 32'd0;
            err_reg   <= 1'b0;
            mask_reg  <= 8'd0;
            rr_reg    <= 8'd0;
            imp_reg   <= 8'd0;
            cdlen_reg <= 8'd0;
            cglen_reg <= 8'd0;
            seq_reg   <= 32'd0;
            plen_reg  <= 16'd0;
            cdoff_reg <= 16'd0;
            cgoff_reg <= 16'd0;
            poff_reg  <= 16'd0;
        end
        else if (in_xfer)
        begin
            if (last_byte)
            begin
                phase_reg <= suaihp_pkg::PH_HDR;
                pos_reg   <= 16'd0;
                count_reg <= 16'd0;
                shift_reg <= 32'd0;
                err_reg   <= 1'b0;
                mask_reg  <= 8'd0;
                rr_reg    <= 8'd0;
                imp_reg   <= 8'd0;
                cdlen_reg <= 8'd0;
                cglen_reg <= 8'd0;
                seq_reg   <= 32'd0;
                plen_reg  <= 16'd0;
                cdoff_reg <= 16'd0;
                cgoff_reg <= 16'd0;
                poff_reg  <= 16'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                shift_reg <= shift_next;
                mask_reg  <= mask_next;
                rr_reg    <= rr_next;
                imp_reg   <= imp_next;
                cdlen_reg <= cdlen_next;
                cglen_reg <= cglen_next;
                seq_reg   <= seq_next;
                plen_reg  <= plen_next;
                cdoff_reg <= cdoff_next;
                cgoff_reg <= cgoff_next;
                poff_reg  <= poff_next;
                // The position saturates; running past it marks the message bad.
                if (pos_reg == 16'hFFFF)
                    err_reg <= 1'b1;
                else
                    pos_reg <= pos_inc;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer && last_byte)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result fields; everything reads as zero on a failed parse.
    always_ff @(posedge clk)
    begin
        if (in_xfer && last_byte)
        begin
            parse_ok         <= ok_next;
            fields_mask      <= ok_next ? mask_next : 8'd0;
            sequence_control <= (ok_next && !mode_reg) ? seq_next : 32'd0;
            called_offset    <= ok_next ? cdoff_next : 16'd0;
            called_length    <= ok_next ? cdlen_next : 8'd0;
            calling_offset   <= ok_next ? cgoff_next : 16'd0;
            calling_length   <= ok_next ? cglen_next : 8'd0;
            return_reason    <= (ok_next && mode_reg) ? rr_next : 8'd0;
            payload_offset   <= ok_next ? poff_next : 16'd0;
            payload_length   <= ok_next ? plen_next : 16'd0;
            importance       <= (ok_next && mode_reg) ? imp_next : 8'd0;
        end
    end

    // A last byte always yields a result in the next cycle.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && last_byte |=> out_valid)
        else $error("last byte accepted without a result");

    // The parser rearms after each message.
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && last_byte |=> phase_reg == suaihp_pkg::PH_HDR && pos_reg == 16'd0
                                 && !err_reg)
        else $error("parse state not cleared after the last byte");

    // A failed parse reports no field values.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parse_ok |-> fields_mask == 8'd0 && sequence_control == 32'd0
                                   && payload_length == 16'd0 && called_length == 8'd0)
        else $error("failed result carries field values");

    // Input stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // Unitdata results never carry notice-only fields.
    a_mode_fields: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && last_byte && !mode_reg |=> return_reason == 8'd0 && importance == 8'd0)
        else $error("notice fields set in unitdata mode");

endmodule

`default_nettype wire

// ===== dv/tb_sua_indication_header_parser.sv =====
// Self-checking testbench for the SUA indication header parser: directed and random messages
// go in byte by byte, and every result is compared with a behavioural prediction of the parser.
// Depends on suaihp_pkg and sua_indication_header_parser.
module tb_sua_indication_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    // One parse result, as the block reports it.
    typedef struct {
        bit        parse_ok;
        bit [7:0]  fields_mask;
        bit [31:0] sequence_control;
        bit [15:0] called_offset;
        bit [7:0]  called_length;
        bit [15:0] calling_offset;
        bit [7:0]  calling_length;
        bit [7:0]  return_reason;
        bit [15:0] payload_offset;
        bit [15:0] payload_length;
        bit [7:0]  importance;
    } header_fields_t;

    typedef struct {
        bit [7:0] data;
        bit       is_last;
    } msg_byte_t;

    localparam bit MODE_UNITDATA      = 1'b0;
    localparam bit MODE_NOTICE        = 1'b1;
    localparam int HEADER_LAST_POS    = 7;
    localparam int MIN_LEN_UNITDATA   = 14;
    localparam int MIN_LEN_NOTICE     = 15;
    localparam int BIG_PAYLOAD        = 65523;
    localparam int RANDOM_BYTES       = 1200;
    localparam int WATCHDOG_LIMIT     = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        parse_ok;
    logic [7:0]  fields_mask;
    logic [31:0] sequence_control;
    logic [15:0] called_offset;
    logic [7:0]  called_length;
    logic [15:0] calling_offset;
    logic [7:0]  calling_length;
    logic [7:0]  return_reason;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [7:0]  importance;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Configuration as the parser sees it, and the parser's message state.
    bit                 mode_cfg = MODE_UNITDATA;
    bit [7:0]           seq_mask_cfg = 8'h01;
    bit [7:0]           imp_mask_cfg = 8'h01;
    bit [15:0]          pos_q;
    suaihp_pkg::phase_t phase_q = suaihp_pkg::PH_HDR;
    bit [15:0]          countdown_q;
    bit [31:0]          shift_q;
    bit                 overrun_q;
    header_fields_t     captured;

    header_fields_t awaited_headers[$];
    header_fields_t head_hdr;
    msg_byte_t      pending_bytes[$];
    msg_byte_t      next_byte;
    bit [7:0]       msg[$];

    int          mismatches = 0;
    int          stall_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          pattern_age = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          random_sent = 0;

    sua_indication_header_parser dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .parse_ok         (parse_ok),
        .fields_mask      (fields_mask),
        .sequence_control (sequence_control),
        .called_offset    (called_offset),
        .called_length    (called_length),
        .calling_offset   (calling_offset),
        .calling_length   (calling_length),
        .return_reason    (return_reason),
        .payload_offset   (payload_offset),
        .payload_length   (payload_length),
        .importance       (importance),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg_text);
        $display("%0t: ERROR %s", $realtime, msg_text);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got_val,
                                 input logic [31:0] exp_val);
        if (got_val !== exp_val)
            note_mismatch($sformatf("%s: got %0h, expected %0h", name, got_val, exp_val));
    endtask

    // Clears the per-message state, as the parser does after every last byte.
    function automatic void clear_parse();
        pos_q = '0;
        phase_q = suaihp_pkg::PH_HDR;
        countdown_q = '0;
        shift_q = '0;
        overrun_q = 1'b0;
        captured = '{default: '0};
    endfunction

    // Counts down a variable-length field and moves on when it is used up.
    function automatic void step_countdown(input suaihp_pkg::phase_t next_phase);
        if (countdown_q <= 16'd1)
        begin
            countdown_q = '0;
            phase_q = next_phase;
        end
        else
            countdown_q = countdown_q - 16'd1;
    endfunction

    // Walks the layout by one byte; on a last byte it queues the expected result.
    task automatic advance_parser(input bit [7:0] b, input bit is_last);
        bit [15:0]      pos;
        bit [15:0]      dlen;
        int unsigned    msg_len;
        bit             ok;
        header_fields_t res;
        pos = pos_q;
        case (phase_q)
            suaihp_pkg::PH_HDR:
                if (pos >= HEADER_LAST_POS) phase_q = suaihp_pkg::PH_MASK;
            suaihp_pkg::PH_MASK:
            begin
                captured.fields_mask = b;
                if (mode_cfg == MODE_UNITDATA && (b & seq_mask_cfg) != 8'd0)
                begin
                    countdown_q = 16'd4;
                    shift_q = '0;
                    phase_q = suaihp_pkg::PH_SEQ;
                end
                else
                    phase_q = suaihp_pkg::PH_CDLEN;
            end
            suaihp_pkg::PH_SEQ:
            begin
                shift_q = {b, shift_q[31:8]};
                if (countdown_q <= 16'd1) captured.sequence_control = shift_q;
                step_countdown(suaihp_pkg::PH_CDLEN);
            end
            suaihp_pkg::PH_CDLEN:
            begin
                captured.called_length = b;
                captured.called_offset = pos + 16'd1;
                countdown_q = {8'd0, b};
                phase_q = (b == 8'd0) ? suaihp_pkg::PH_CGLEN : suaihp_pkg::PH_CDADDR;
            end
            suaihp_pkg::PH_CDADDR:
                step_countdown(suaihp_pkg::PH_CGLEN);
            suaihp_pkg::PH_CGLEN:
            begin
                captured.calling_length = b;
                captured.calling_offset = pos + 16'd1;
                countdown_q = {8'd0, b};
                if (b != 8'd0)
                    phase_q = suaihp_pkg::PH_CGADDR;
                else
                    phase_q = (mode_cfg == MODE_NOTICE) ? suaihp_pkg::PH_RR
                                                        : suaihp_pkg::PH_DLEN0;
            end
            suaihp_pkg::PH_CGADDR:
                step_countdown((mode_cfg == MODE_NOTICE) ? suaihp_pkg::PH_RR
                                                         : suaihp_pkg::PH_DLEN0);
            suaihp_pkg::PH_RR:
            begin
                captured.return_reason = b;
                phase_q = suaihp_pkg::PH_DLEN0;
            end
            suaihp_pkg::PH_DLEN0:
            begin
                shift_q = {24'd0, b};
                phase_q = suaihp_pkg::PH_DLEN1;
            end
            suaihp_pkg::PH_DLEN1:
            begin
                dlen = {b, shift_q[7:0]};
                captured.payload_length = dlen;
                captured.payload_offset = pos + 16'd1;
                countdown_q = dlen;
                phase_q = (dlen == 16'd0) ? suaihp_pkg::PH_POST : suaihp_pkg::PH_DATA;
            end
            suaihp_pkg::PH_DATA:
                step_countdown(suaihp_pkg::PH_POST);
            suaihp_pkg::PH_POST:
            begin
                if (mode_cfg == MODE_NOTICE && (captured.fields_mask & imp_mask_cfg) != 8'd0)
                    captured.importance = b;
                phase_q = suaihp_pkg::PH_TAIL;
            end
            default:
                phase_q = suaihp_pkg::PH_TAIL;
        endcase

        if (!is_last)
        begin
            // The position saturates; a byte beyond it marks the message as overlong.
            if (pos == 16'hFFFF)
                overrun_q = 1'b1;
            else
                pos_q = pos + 16'd1;
        end
        else
        begin
            msg_len = pos + 1;
            ok = !overrun_q && phase_q >= suaihp_pkg::PH_POST &&
                 msg_len >= ((mode_cfg == MODE_NOTICE) ? MIN_LEN_NOTICE : MIN_LEN_UNITDATA);
            res = '{default: '0};
            if (ok)
            begin
                res = captured;
                res.parse_ok = 1'b1;
                if (mode_cfg == MODE_NOTICE)
                    res.sequence_control = '0;
                else
                begin
                    res.return_reason = '0;
                    res.importance = '0;
                end
            end
            awaited_headers.push_back(res);
            clear_parse();
        end
    endtask

    // Byte sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                next_byte = pending_bytes.pop_front();
                in_valid <= 1'b1;
                data_byte <= next_byte.data;
                last_byte <= next_byte.is_last;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                             : $urandom_range(1, 24);
                    gap_left = $urandom_range(1, 12);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: a rotating ready pattern, reloaded now and then.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom) | 16'h0001;
                    2: ready_pattern = 16'h0001;
                    default: ready_pattern = 16'h5555;
                endcase
                pattern_age = $urandom_range(32, 160);
            end
            pattern_age--;
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
            out_ready <= ready_pattern[0];
        end
    end

    // Monitor: checks each result transfer, predicts from each byte transfer, and
    // ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_headers.size() == 0)
                    note_mismatch("result transfer with no message outstanding");
                else
                begin
                    head_hdr = awaited_headers.pop_front();
                    compare_field("parse_ok", parse_ok, head_hdr.parse_ok);
                    compare_field("fields_mask", fields_mask, head_hdr.fields_mask);
                    compare_field("sequence_control", sequence_control,
                                  head_hdr.sequence_control);
                    compare_field("called_offset", called_offset, head_hdr.called_offset);
                    compare_field("called_length", called_length, head_hdr.called_length);
                    compare_field("calling_offset", calling_offset, head_hdr.calling_offset);
                    compare_field("calling_length", calling_length, head_hdr.calling_length);
                    compare_field("return_reason", return_reason, head_hdr.return_reason);
                    compare_field("payload_offset", payload_offset, head_hdr.payload_offset);
                    compare_field("payload_length", payload_length, head_hdr.payload_length);
                    compare_field("importance", importance, head_hdr.importance);
                end
            end
            if (in_valid && in_ready)
                advance_parser(data_byte, last_byte);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input suaihp_pkg::reg_idx_t idx, input bit [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            suaihp_pkg::REG_FORMAT_MODE: mode_cfg = value[0];
            suaihp_pkg::REG_SEQ_MASK:    seq_mask_cfg = value;
            suaihp_pkg::REG_IMP_MASK:    imp_mask_cfg = value;
            default: ;
        endcase
    endtask

    task automatic check_reg(input suaihp_pkg::reg_idx_t idx, input bit [7:0] want);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        compare_field($sformatf("register %0d read", idx), prdata, {24'd0, want});
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input bit fmt, input bit [7:0] seq_mask,
                                input bit [7:0] imp_mask);
        write_reg(suaihp_pkg::REG_FORMAT_MODE, {7'd0, fmt});
        write_reg(suaihp_pkg::REG_SEQ_MASK, seq_mask);
        write_reg(suaihp_pkg::REG_IMP_MASK, imp_mask);
        check_reg(suaihp_pkg::REG_FORMAT_MODE, {7'd0, fmt});
        check_reg(suaihp_pkg::REG_SEQ_MASK, seq_mask);
        check_reg(suaihp_pkg::REG_IMP_MASK, imp_mask);
    endtask

    // Holds back until every byte is taken and every result has arrived.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || awaited_headers.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic put_random(input int count);
        repeat (count) msg.push_back(8'($urandom));
    endtask

    // Builds a message for the current layout; data_sent may fall short of data_len.
    task automatic compose(input bit [7:0] mask, input bit [31:0] seq, input int called_len,
                           input int calling_len, input bit [7:0] reason, input int data_len,
                           input int data_sent, input int tail_len);
        put_random(8);
        msg.push_back(mask);
        if (mode_cfg == MODE_UNITDATA && (mask & seq_mask_cfg) != 8'd0)
        begin
            msg.push_back(seq[7:0]);
            msg.push_back(seq[15:8]);
            msg.push_back(seq[23:16]);
            msg.push_back(seq[31:24]);
        end
        msg.push_back(8'(called_len));
        put_random(called_len);
        msg.push_back(8'(calling_len));
        put_random(calling_len);
        if (mode_cfg == MODE_NOTICE) msg.push_back(reason);
        msg.push_back(8'(data_len));
        msg.push_back(8'(data_len >> 8));
        put_random(data_sent);
        put_random(tail_len);
    endtask

    task automatic send_message();
        foreach (msg[i])
            pending_bytes.push_back('{data: msg[i], is_last: (i == msg.size() - 1)});
        msg.delete();
    endtask

    function automatic bit [7:0] pick_mask();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01 << $urandom_range(0, 7);
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed messages with random content; the rest cut short or plain noise.
    task automatic random_message();
        int kind;
        int cd;
        int cg;
        int dl;
        int cut;
        kind = $urandom_range(0, 19);
        cd = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
        cg = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
        dl = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 8);
        if (kind < 14)
            compose(8'($urandom), $urandom, cd, cg, 8'($urandom), dl, dl, $urandom_range(0, 3));
        else if (kind < 17)
        begin
            compose(8'($urandom), $urandom, cd, cg, 8'($urandom),
                    $urandom_range(0, 1) ? int'(16'($urandom)) : dl, dl, 0);
            cut = $urandom_range(0, msg.size() - 1);
            repeat (cut) void'(msg.pop_back());
        end
        else
            put_random($urandom_range(1, 30));
        random_sent += msg.size();
        send_message();
    endtask

    initial
    begin
        int phase_target;
        clear_parse();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Registers must come out of reset with their defaults.
        check_reg(suaihp_pkg::REG_FORMAT_MODE, 8'h00);
        check_reg(suaihp_pkg::REG_SEQ_MASK, 8'h01);
        check_reg(suaihp_pkg::REG_IMP_MASK, 8'h01);

        // Unitdata layout: too short, minimum, field extremes, truncated user data.
        apply_config(MODE_UNITDATA, 8'h01, 8'h01);
        msg.push_back(8'($urandom));
        send_message();
        compose(8'h00, 32'd0, 0, 0, 8'd0, 0, 0, 0);
        send_message();
        compose(8'h00, 32'd0, 0, 0, 8'd0, 0, 0, 1);
        send_message();
        compose(8'h01, 32'hFFFF_FFFF, 255, 255, 8'd0, 3, 3, 2);
        send_message();
        compose(8'hFF, 32'd0, 1, 0, 8'd0, 0, 0, 1);
        send_message();
        compose(8'hFE, 32'd0, 2, 2, 8'd0, 5, 5, 0);
        repeat (2) void'(msg.pop_back());
        send_message();
        compose(8'h00, 32'd0, 0, 0, 8'd0, 16'hFFFF, 6, 0);
        send_message();
        wait_until_drained();

        // Largest message that still fits, then one byte past the position limit.
        compose(8'h00, 32'd0, 0, 0, 8'd0, BIG_PAYLOAD, BIG_PAYLOAD, 0);
        send_message();
        compose(8'h00, 32'd0, 0, 0, 8'd0, BIG_PAYLOAD, BIG_PAYLOAD, 1);
        send_message();
        wait_until_drained();

        // Notice layout: too short, importance present, missing, and with trailing bytes.
        apply_config(MODE_NOTICE, 8'h00, 8'hFF);
        compose(8'h00, 32'd0, 0, 0, 8'h00, 0, 0, 0);
        send_message();
        compose(8'h01, 32'd0, 0, 0, 8'hFF, 0, 0, 1);
        send_message();
        compose(8'h80, 32'd0, 2, 3, 8'hFF, 4, 4, 0);
        send_message();
        compose(8'hFF, 32'hFFFF_FFFF, 1, 1, 8'h00, 2, 2, 3);
        send_message();
        wait_until_drained();

        // Importance byte there but not flagged by the mask.
        apply_config(MODE_NOTICE, 8'hFF, 8'h00);
        compose(8'hFF, 32'd0, 1, 2, 8'h5A, 1, 1, 2);
        send_message();
        wait_until_drained();

        // Sequence control switched off, then flagged by any mask bit.
        apply_config(MODE_UNITDATA, 8'h00, 8'hFF);
        compose(8'hFF, 32'hA5C3_0F96, 1, 1, 8'd0, 2, 2, 1);
        send_message();
        wait_until_drained();
        apply_config(MODE_UNITDATA, 8'hFF, 8'h00);
        compose(8'h80, 32'hA5C3_0F96, 2, 1, 8'd0, 3, 3, 0);
        send_message();
        compose(8'h00, 32'd0, 0, 3, 8'd0, 1, 1, 0);
        send_message();
        wait_until_drained();

        // Random phases, each under a fresh register setting.
        while (random_sent < RANDOM_BYTES)
        begin
            apply_config(bit'($urandom_range(0, 1)), pick_mask(), pick_mask());
            phase_target = random_sent + $urandom_range(100, 300);
            while (random_sent < phase_target)
                random_message();
            wait_until_drained();
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/suaihp_pkg.sv
rtl/sua_indication_header_parser.sv
dv/tb_sua_indication_header_parser.sv
